@@ design/pps_pkg.sv @@
// Shared types, codes and constants for the pure pursuit steering block.
// No dependencies; every other design file but pps_alu refers to it by scoped names.
package pps_pkg;

    localparam int MAX_WAYPOINTS_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 104;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CMD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH = 3'd3;

    localparam logic [20:0]        LOOKAHEAD_RST = 21'd19661;
    localparam logic [12:0]        MAX_STEER_RST = 13'd1638;
    localparam logic signed [15:0] SPEED_RST     = 16'sd512;
    localparam logic [10:0]        PATH_LEN_RST  = 11'd1;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ODOM = 1'b1;

    localparam int QUAT_STEPS = 6;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_Q_W    = 15;
    localparam logic signed [15:0] UNIT_COS = 16'sd16384;

    typedef struct packed {
        logic [20:0]        lookahead;
        logic [12:0]        max_steer;
        logic signed [15:0] speed_cmd;
        logic [10:0]        path_length;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [9:0]         wp_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic signed [13:0] steer;
        logic [9:0]         goal_index;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } result_t;

    typedef enum logic [1:0] {PH_SCAN, PH_TRACK, PH_GOAL} phase_t;

    typedef enum logic [1:0] {DV_SIN, DV_COS, DV_STEER} div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LA2, S_QUAT, S_S4C4, S_SQ_S, S_SQ_C, S_SQRT, S_YAW,
        S_DIV_INIT, S_DIV, S_DIV_FIN, S_TGT, S_RD, S_SUB, S_MX, S_MY,
        S_EVAL, S_NX, S_NY, S_STEER, S_DONE
    } state_t;

endpackage

@@ design/pps_wp_mem.sv @@
// Waypoint table: one write port, one registered read port, x in the low word.
// Depends on pps_pkg for the default depth.
module pps_wp_mem #(
    parameter int DEPTH = pps_pkg::MAX_WAYPOINTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pps_alu.sv @@
// Shared arithmetic unit: one signed 33x33 multiplier and one 65-bit
// subtract/compare shared by the steps of the sequencer. No dependencies.
module pps_alu (
    input  logic signed [32:0] mul_a,
    input  logic signed [32:0] mul_b,
    output logic signed [65:0] prod,
    input  logic [64:0]        cmp_a,
    input  logic [63:0]        cmp_b,
    output logic               ge,
    output logic [64:0]        diff
);

    logic [65:0] sub_full;

    assign prod     = 66'(mul_a) * 66'(mul_b);
    assign sub_full = {1'b0, cmp_a} - {2'b00, cmp_b};
    assign diff     = sub_full[64:0];
    assign ge       = ~sub_full[65];

endmodule

@@ design/pps_core.sv @@
// Sequencer and datapath registers: yaw from the quaternion, target search,
// steer division. Depends on pps_pkg, pps_alu and pps_wp_mem.
module pps_core #(
    parameter int MAX_WAYPOINTS = pps_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::cfg_t     cfg,
    input  logic              in_accept,
    input  pps_pkg::in_item_t in_item,
    output logic              in_ready,
    input  logic              out_busy,
    output logic              done,
    output pps_pkg::result_t  result
);

    localparam int AW  = $clog2(MAX_WAYPOINTS);
    localparam int NW  = $clog2(MAX_WAYPOINTS + 1);
    localparam int CW  = (NW > 11) ? NW : 11;

    pps_pkg::state_t   state_reg, state_next;
    pps_pkg::phase_t   phase_reg;
    pps_pkg::div_sel_t div_sel_reg;

    logic              acquired_reg;
    logic [AW-1:0]     target_reg;
    logic [CW-1:0]     idx_reg, best_i_reg;
    logic              found_reg;
    logic [4:0]        cnt_reg;

    logic signed [31:0] cx_reg, cy_reg, gx_reg, gy_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic [41:0]        la2_reg;
    logic signed [65:0] acc_reg;
    logic signed [32:0] s4_reg, c4_reg, dx_reg, dy_reg;
    logic [63:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]        r_reg;
    logic [63:0]        div_rem_reg, div_sh_reg;
    logic [DIV_QW_M1:0] div_q_reg;
    localparam int DIV_QW_M1 = pps_pkg::DIV_Q_W - 1;
    logic               div_ovf_reg;
    logic               sat_reg;
    logic [63:0]        d_reg, best_reg;
    logic signed [49:0] num_reg;
    logic signed [13:0] steer_reg;

    // shared unit hookup
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [64:0]        cmp_a, diff;
    logic [63:0]        cmp_b;
    logic               ge;

    pps_alu u_alu (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .cmp_a (cmp_a),
        .cmp_b (cmp_b),
        .ge    (ge),
        .diff  (diff)
    );

    logic          mem_we;
    logic [63:0]   mem_rdata;

    pps_wp_mem #(
        .DEPTH (MAX_WAYPOINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_item.wp_index)),
        .wdata ({in_item.coord_y, in_item.coord_x}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign mem_we = in_accept && (in_item.req_type == pps_pkg::REQ_LOAD) &&
                    (32'(in_item.wp_index) < 32'(MAX_WAYPOINTS));

    // effective path length
    logic [CW-1:0] plen, n_eff;
    always_comb
    begin
        plen = CW'(cfg.path_length);
        if (plen == '0)
            n_eff = CW'(1);
        else if (plen > CW'(MAX_WAYPOINTS))
            n_eff = CW'(MAX_WAYPOINTS);
        else
            n_eff = plen;
    end

    // magnitudes and divider operands
    logic [32:0] s4_mag, c4_mag;
    logic [49:0] num_mag;
    logic [63:0] div_dvd, div_dvs;
    assign s4_mag  = s4_reg[32] ? 33'(-s4_reg) : 33'(s4_reg);
    assign c4_mag  = c4_reg[32] ? 33'(-c4_reg) : 33'(c4_reg);
    assign num_mag = num_reg[49] ? 50'(-num_reg) : 50'(num_reg);

    always_comb
    begin
        case (div_sel_reg)
            pps_pkg::DV_SIN:
            begin
                div_dvd = 64'(s4_mag) << 14;
                div_dvs = 64'(r_reg);
            end
            pps_pkg::DV_COS:
            begin
                div_dvd = 64'(c4_mag) << 14;
                div_dvs = 64'(r_reg);
            end
            default:
            begin
                div_dvd = 64'(num_mag) << 15;
                div_dvs = d_reg;
            end
        endcase
    end

    // truncation toward zero of s/2 and c/4
    logic signed [32:0] s4_adj, c4_adj;
    assign s4_adj = s4_reg + $signed({32'b0, s4_reg[32]});
    assign c4_adj = c4_reg + $signed({31'b0, {2{c4_reg[32]}}});

    // car-relative offsets of the waypoint just read
    logic signed [32:0] dx_new, dy_new;
    logic               sat_new;
    assign dx_new  = $signed({mem_rdata[31], mem_rdata[31:0]}) - 33'(cx_reg);
    assign dy_new  = $signed({mem_rdata[63], mem_rdata[63:32]}) - 33'(cy_reg);
    assign sat_new = (dx_new[32] != dx_new[31]) || (dx_new == {2'b11, 31'b0}) ||
                     (dy_new[32] != dy_new[31]) || (dy_new == {2'b11, 31'b0});

    // target selection
    logic          upd, f_new, scan_last;
    logic [CW-1:0] bi_new, bi_inc, t_cur, t_inc;
    logic [AW-1:0] scan_tgt, track_tgt;
    always_comb
    begin
        upd       = (d_reg > 64'(la2_reg)) && (!found_reg || (d_reg < best_reg));
        f_new     = found_reg || upd;
        bi_new    = upd ? idx_reg : best_i_reg;
        bi_inc    = bi_new + CW'(1);
        scan_last = (idx_reg + CW'(1)) >= n_eff;
        if (!f_new || (bi_inc >= n_eff))
            scan_tgt = '0;
        else
            scan_tgt = bi_inc[AW-1:0];
        t_cur = CW'(target_reg);
        t_inc = t_cur + CW'(1);
        if (d_reg < 64'(la2_reg))
            track_tgt = (t_inc >= n_eff) ? '0 : t_inc[AW-1:0];
        else
            track_tgt = target_reg;
    end

    // steer clamp
    logic [12:0]        st_mag;
    logic signed [13:0] st_pos;
    logic               num_pos;
    logic [15:0]        q16;
    assign st_mag  = (div_ovf_reg || (div_q_reg > 15'(cfg.max_steer))) ?
                     cfg.max_steer : div_q_reg[12:0];
    assign st_pos  = $signed({1'b0, st_mag});
    assign num_pos = !num_reg[49] && (num_reg != '0);
    assign q16     = {1'b0, div_q_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::S_IDLE:
                if (in_accept && (in_item.req_type == pps_pkg::REQ_ODOM))
                    state_next = pps_pkg::S_LA2;
            pps_pkg::S_LA2:  state_next = pps_pkg::S_QUAT;
            pps_pkg::S_QUAT:
                if (cnt_reg == 5'(pps_pkg::QUAT_STEPS - 1))
                    state_next = pps_pkg::S_S4C4;
            pps_pkg::S_S4C4: state_next = pps_pkg::S_SQ_S;
            pps_pkg::S_SQ_S: state_next = pps_pkg::S_SQ_C;
            pps_pkg::S_SQ_C: state_next = pps_pkg::S_SQRT;
            pps_pkg::S_SQRT:
                if (cnt_reg == 5'(pps_pkg::SQRT_STEPS - 1))
                    state_next = pps_pkg::S_YAW;
            pps_pkg::S_YAW:
                state_next = (sq_res_reg == '0) ? pps_pkg::S_TGT : pps_pkg::S_DIV_INIT;
            pps_pkg::S_DIV_INIT: state_next = pps_pkg::S_DIV;
            pps_pkg::S_DIV:
                if (cnt_reg == 5'(pps_pkg::DIV_Q_W - 1))
                    state_next = pps_pkg::S_DIV_FIN;
            pps_pkg::S_DIV_FIN:
                case (div_sel_reg)
                    pps_pkg::DV_SIN: state_next = pps_pkg::S_DIV_INIT;
                    pps_pkg::DV_COS: state_next = pps_pkg::S_TGT;
                    default:         state_next = pps_pkg::S_DONE;
                endcase
            pps_pkg::S_TGT:  state_next = pps_pkg::S_RD;
            pps_pkg::S_RD:   state_next = pps_pkg::S_SUB;
            pps_pkg::S_SUB:  state_next = pps_pkg::S_MX;
            pps_pkg::S_MX:   state_next = pps_pkg::S_MY;
            pps_pkg::S_MY:   state_next = pps_pkg::S_EVAL;
            pps_pkg::S_EVAL:
                state_next = (phase_reg == pps_pkg::PH_GOAL) ? pps_pkg::S_NX : pps_pkg::S_RD;
            pps_pkg::S_NX:   state_next = pps_pkg::S_NY;
            pps_pkg::S_NY:   state_next = pps_pkg::S_STEER;
            pps_pkg::S_STEER:
                state_next = (sat_reg || (d_reg == '0)) ? pps_pkg::S_DONE : pps_pkg::S_DIV_INIT;
            pps_pkg::S_DONE:
                if (!out_busy)
                    state_next = pps_pkg::S_IDLE;
            default: state_next = pps_pkg::S_IDLE;
        endcase
    end

    // shared unit operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            pps_pkg::S_LA2:
            begin
                mul_a = $signed(33'(cfg.lookahead));
                mul_b = $signed(33'(cfg.lookahead));
            end
            pps_pkg::S_QUAT:
                case (cnt_reg)
                    5'd0:    begin mul_a = 33'(qw_reg); mul_b = 33'(qz_reg); end
                    5'd1:    begin mul_a = 33'(qx_reg); mul_b = 33'(qy_reg); end
                    5'd2:    begin mul_a = 33'(qw_reg); mul_b = 33'(qw_reg); end
                    5'd3:    begin mul_a = 33'(qx_reg); mul_b = 33'(qx_reg); end
                    5'd4:    begin mul_a = 33'(qy_reg); mul_b = 33'(qy_reg); end
                    default: begin mul_a = 33'(qz_reg); mul_b = 33'(qz_reg); end
                endcase
            pps_pkg::S_SQ_S: begin mul_a = s4_reg; mul_b = s4_reg; end
            pps_pkg::S_SQ_C: begin mul_a = c4_reg; mul_b = c4_reg; end
            pps_pkg::S_SQRT:
            begin
                cmp_a = {1'b0, sq_v_reg};
                cmp_b = sq_res_reg | sq_bit_reg;
            end
            pps_pkg::S_DIV_INIT:
            begin
                cmp_a = {1'b0, div_dvd >> pps_pkg::DIV_Q_W};
                cmp_b = div_dvs;
            end
            pps_pkg::S_DIV:
            begin
                cmp_a = {div_rem_reg, div_sh_reg[63]};
                cmp_b = div_dvs;
            end
            pps_pkg::S_MX:   begin mul_a = dx_reg; mul_b = dx_reg; end
            pps_pkg::S_MY:   begin mul_a = dy_reg; mul_b = dy_reg; end
            pps_pkg::S_NX:   begin mul_a = dx_reg; mul_b = 33'(sin_reg); end
            pps_pkg::S_NY:   begin mul_a = dy_reg; mul_b = 33'(cos_reg); end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pps_pkg::S_IDLE;
            acquired_reg <= 1'b0;
            target_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pps_pkg::S_TGT && acquired_reg && (CW'(target_reg) >= n_eff))
                target_reg <= '0;
            if (state_reg == pps_pkg::S_EVAL)
            begin
                if (phase_reg == pps_pkg::PH_SCAN && scan_last)
                begin
                    target_reg   <= scan_tgt;
                    acquired_reg <= 1'b1;
                end
                else if (phase_reg == pps_pkg::PH_TRACK)
                    target_reg <= track_tgt;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pps_pkg::S_IDLE:
                if (in_accept)
                begin
                    cx_reg <= in_item.coord_x;
                    cy_reg <= in_item.coord_y;
                    qx_reg <= in_item.quat_x;
                    qy_reg <= in_item.quat_y;
                    qz_reg <= in_item.quat_z;
                    qw_reg <= in_item.quat_w;
                end
            pps_pkg::S_LA2:
            begin
                la2_reg <= prod[41:0];
                cnt_reg <= '0;
            end
            pps_pkg::S_QUAT:
            begin
                case (cnt_reg)
                    5'd0, 5'd2: acc_reg <= prod;
                    5'd1:       s4_reg  <= 33'(acc_reg + prod);
                    5'd3:       acc_reg <= acc_reg + prod;
                    5'd4:       acc_reg <= acc_reg - prod;
                    default:    c4_reg  <= 33'(acc_reg - prod);
                endcase
                cnt_reg <= cnt_reg + 5'd1;
            end
            pps_pkg::S_S4C4:
            begin
                s4_reg <= s4_adj >>> 1;
                c4_reg <= c4_adj >>> 2;
            end
            pps_pkg::S_SQ_S: acc_reg <= prod;
            pps_pkg::S_SQ_C:
            begin
                sq_v_reg   <= 64'(acc_reg + prod);
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg    <= '0;
            end
            pps_pkg::S_SQRT:
            begin
                if (ge)
                begin
                    sq_v_reg   <= diff[63:0];
                    sq_res_reg <= (sq_res_reg >> 1) | sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 5'd1;
            end
            pps_pkg::S_YAW:
            begin
                r_reg       <= sq_res_reg[31:0];
                div_sel_reg <= pps_pkg::DV_SIN;
                if (sq_res_reg == '0)
                begin
                    sin_reg <= '0;
                    cos_reg <= pps_pkg::UNIT_COS;
                end
            end
            pps_pkg::S_DIV_INIT:
            begin
                div_ovf_reg <= ge;
                div_rem_reg <= div_dvd >> pps_pkg::DIV_Q_W;
                div_sh_reg  <= div_dvd << (64 - pps_pkg::DIV_Q_W);
                div_q_reg   <= '0;
                cnt_reg     <= '0;
            end
            pps_pkg::S_DIV:
            begin
                if (ge)
                begin
                    div_rem_reg <= diff[63:0];
                    div_q_reg   <= {div_q_reg[DIV_QW_M1-1:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= cmp_a[63:0];
                    div_q_reg   <= {div_q_reg[DIV_QW_M1-1:0], 1'b0};
                end
                div_sh_reg <= div_sh_reg << 1;
                cnt_reg    <= cnt_reg + 5'd1;
            end
            pps_pkg::S_DIV_FIN:
                case (div_sel_reg)
                    pps_pkg::DV_SIN:
                    begin
                        sin_reg     <= s4_reg[32] ? -$signed(q16) : $signed(q16);
                        div_sel_reg <= pps_pkg::DV_COS;
                    end
                    pps_pkg::DV_COS:
                        cos_reg <= c4_reg[32] ? -$signed(q16) : $signed(q16);
                    default:
                        steer_reg <= num_pos ? -st_pos : st_pos;
                endcase
            pps_pkg::S_TGT:
                if (!acquired_reg)
                begin
                    phase_reg <= pps_pkg::PH_SCAN;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                end
                else
                begin
                    phase_reg <= pps_pkg::PH_TRACK;
                    idx_reg   <= (CW'(target_reg) >= n_eff) ? '0 : CW'(target_reg);
                end
            pps_pkg::S_SUB:
            begin
                dx_reg  <= dx_new;
                dy_reg  <= dy_new;
                sat_reg <= sat_new;
                gx_reg  <= $signed(mem_rdata[31:0]);
                gy_reg  <= $signed(mem_rdata[63:32]);
            end
            pps_pkg::S_MX: acc_reg <= prod;
            pps_pkg::S_MY: d_reg <= sat_reg ? '1 : (acc_reg[63:0] + prod[63:0]);
            pps_pkg::S_EVAL:
                case (phase_reg)
                    pps_pkg::PH_SCAN:
                    begin
                        if (upd)
                        begin
                            found_reg  <= 1'b1;
                            best_reg   <= d_reg;
                            best_i_reg <= idx_reg;
                        end
                        if (scan_last)
                        begin
                            phase_reg <= pps_pkg::PH_GOAL;
                            idx_reg   <= CW'(scan_tgt);
                        end
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                    pps_pkg::PH_TRACK:
                    begin
                        phase_reg <= pps_pkg::PH_GOAL;
                        idx_reg   <= CW'(track_tgt);
                    end
                    default: ;
                endcase
            pps_pkg::S_NX: acc_reg <= prod;
            pps_pkg::S_NY: num_reg <= 50'(acc_reg - prod);
            pps_pkg::S_STEER:
            begin
                div_sel_reg <= pps_pkg::DV_STEER;
                if (sat_reg || (d_reg == '0))
                    steer_reg <= '0;
            end
            default: ;
        endcase
    end

    assign in_ready          = (state_reg == pps_pkg::S_IDLE);
    assign done              = (state_reg == pps_pkg::S_DONE) && !out_busy;
    assign result.steer      = steer_reg;
    assign result.goal_index = 10'(target_reg);
    assign result.goal_x     = gx_reg;
    assign result.goal_y     = gy_reg;

    // a delivered result always points inside the path in use
    a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CW'(target_reg) < n_eff))
        else $error("goal index beyond path length");

    a_steer_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((steer_reg <= $signed({1'b0, cfg.max_steer})) &&
                  (steer_reg >= -$signed({1'b0, cfg.max_steer}))))
        else $error("steer outside clamp");

    a_sin_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::S_NX) |->
            ((sin_reg <= pps_pkg::UNIT_COS) && (sin_reg >= -pps_pkg::UNIT_COS)))
        else $error("sin of yaw out of unit range");

    a_acquired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        acquired_reg |=> acquired_reg)
        else $error("acquired flag dropped");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == pps_pkg::S_IDLE))
        else $error("sequencer did not return to idle");

endmodule

@@ design/pure_pursuit_steering_top.sv @@
// Pure pursuit steering block: waypoint loads and odometry requests in,
// steering results out. A load request gives no result. The first odometry
// request also scans every waypoint in use to acquire the target, each one
// passing the single table read port and the shared multiplier; later
// requests track from the acquired target. The yaw root (32 steps) and up to
// three 15-step divisions all run on the shared arithmetic unit.
// A finished result sits in the output register, and a new request can be
// taken while it waits. Depends on pps_pkg and pps_core.
module pure_pursuit_steering_top #(
    parameter int MAX_WAYPOINTS = pps_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // wp_index, coord_x, coord_y, quat_x, quat_y, quat_z, quat_w, zero pad
    input  logic [pps_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // steer, speed, goal_index, goal_x, goal_y
    output logic [pps_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    pps_pkg::cfg_t     cfg_reg;
    pps_pkg::in_item_t in_item;
    pps_pkg::result_t  result;
    logic              in_ready, in_accept, done, out_busy;
    logic              m_tvalid_reg;
    logic [pps_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lookahead   <= pps_pkg::LOOKAHEAD_RST;
            cfg_reg.max_steer   <= pps_pkg::MAX_STEER_RST;
            cfg_reg.speed_cmd   <= pps_pkg::SPEED_RST;
            cfg_reg.path_length <= pps_pkg::PATH_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pps_pkg::REG_LOOKAHEAD:   cfg_reg.lookahead   <= cfg_data[20:0];
                pps_pkg::REG_MAX_STEER:   cfg_reg.max_steer   <= cfg_data[12:0];
                pps_pkg::REG_SPEED_CMD:   cfg_reg.speed_cmd   <= $signed(cfg_data[15:0]);
                pps_pkg::REG_PATH_LENGTH: cfg_reg.path_length <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign in_item.req_type = s_tuser[0];
    assign in_item.wp_index = s_tdata[9:0];
    assign in_item.coord_x  = $signed(s_tdata[41:10]);
    assign in_item.coord_y  = $signed(s_tdata[73:42]);
    assign in_item.quat_x   = $signed(s_tdata[89:74]);
    assign in_item.quat_y   = $signed(s_tdata[105:90]);
    assign in_item.quat_z   = $signed(s_tdata[121:106]);
    assign in_item.quat_w   = $signed(s_tdata[137:122]);

    assign s_tready  = in_ready;
    assign in_accept = s_tvalid && in_ready;
    assign out_busy  = m_tvalid_reg && !m_tready;

    pps_core #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_item   (in_item),
        .in_ready  (in_ready),
        .out_busy  (out_busy),
        .done      (done),
        .result    (result)
    );

    // output register: holds a result until the downstream side takes it with m_tready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (done)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            m_tdata_reg <= {result.goal_y, result.goal_x, result.goal_index,
                            cfg_reg.speed_cmd, result.steer};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
